### hw/rtl/vtd_pkg.sv
package vtd_pkg;

    // Tree geometry
    localparam int NODES   = 256;
    localparam int TABLES  = 8;
    localparam int MAX_LEN = 16;

    localparam int NODE_W = $clog2(NODES);
    localparam int CNT_W  = $clog2(NODES + 1);
    localparam int TBL_W  = 3;
    localparam int ADDR_W = $clog2(TABLES) + NODE_W;
    localparam int LEN_W  = 5;
    localparam int CODE_W = 16;
    localparam int VAL_W  = 15;
    localparam int POS_W  = $clog2(CODE_W);

    // Item modes
    localparam logic [1:0] MODE_DECODE = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    typedef enum logic [2:0] {
        ST_MORE     = 3'd0,
        ST_SYMBOL   = 3'd1,
        ST_ADDED    = 3'd2,
        ST_INVALID  = 3'd3,
        ST_FULL     = 3'd4,
        ST_CONFLICT = 3'd5,
        ST_CLEARED  = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC_CUR,
        S_DEC_KID,
        S_ADD_CHK,
        S_ADD_NEW,
        S_RESP
    } t_state;

    // One tree node: two child links with valid bits, leaf flag and value
    typedef struct packed {
        logic [1:0]             has;
        logic [1:0][NODE_W-1:0] kid;
        logic                   leaf;
        logic [VAL_W-1:0]       val;
    } t_node;

endpackage

### hw/rtl/vlc_tree_decoder_top.sv
// Variable-length code decoder over eight binary code trees of 256 nodes each,
// kept in one 2048 x 34 node memory with a registered read. One item is in
// flight at a time. A decode bit that finds a child takes one memory read
// for the cursor node, one for the child node and one result stage. A bit
// that hits an empty branch skips the child read. A successful add takes one
// read per node already on the code's path (root included), one write per
// node it creates and one result stage. A refused add ends right after the
// read that finds the conflict or the shortage. Clear, unused modes and bad
// code lengths go straight to the result stage. The result stage holds while
// the output register is full and its beat is not taken. A node past a
// tree's node count reads as empty, so reset and clear need no sweep of the
// memory and the block accepts items right after reset. A finished result
// waits in an output register while the next item is accepted.
module vlc_tree_decoder_top
    import vtd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_mode,
    input  logic [TBL_W-1:0]  i_table_req,
    input  logic              i_bit_req,
    input  logic [VAL_W-1:0]  i_value,
    input  logic [LEN_W-1:0]  i_code_len,
    input  logic [CODE_W-1:0] i_code,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [2:0]        o_status,
    output logic [VAL_W-1:0]  o_symbol
);

    t_state r_state, n_state;

    // Latched item
    logic [1:0]        r_mode;
    logic [TBL_W-1:0]  r_tbl;
    logic              r_bit;
    logic [VAL_W-1:0]  r_val;
    logic [LEN_W-1:0]  r_len;
    logic [CODE_W-1:0] r_code;

    // Walk state
    logic [LEN_W-1:0]  r_pos, n_pos;
    logic [NODE_W-1:0] r_cur, n_cur;

    // Per-tree state
    logic [CNT_W-1:0]  r_count  [TABLES];
    logic [CNT_W-1:0]  n_count  [TABLES];
    logic [NODE_W-1:0] r_cursor [TABLES];
    logic [NODE_W-1:0] n_cursor [TABLES];

    // Pending result and output register
    t_status          r_res_status, n_res_status;
    logic [VAL_W-1:0] r_res_symbol, n_res_symbol;
    logic             r_o_valid;
    t_status          r_o_status;
    logic [VAL_W-1:0] r_o_symbol;

    // Memory ports
    logic              mem_we;
    logic [NODE_W-1:0] mem_widx;
    t_node             mem_wdata;
    logic [TBL_W-1:0]  rd_tbl;
    logic [NODE_W-1:0] rd_idx;
    t_node             mem_q;
    t_node             rd_node;
    logic              r_rd_ok;
    logic              rd_ok;

    logic              acc_in;
    logic              slot_free;
    logic              tbl_ok;
    logic              len_ok;
    logic [POS_W-1:0]  bit_idx;
    logic              add_b;
    logic [LEN_W-1:0]  need;
    logic              fits;
    logic [CNT_W-1:0]  cur_count;

    assign acc_in    = i_valid && o_ready;
    assign o_ready   = (r_state == S_IDLE);
    assign slot_free = !r_o_valid || i_ready;

    assign tbl_ok = ({1'b0, i_table_req} < (TBL_W+1)'(TABLES));
    assign len_ok = (i_code_len != '0) && (i_code_len <= LEN_W'(MAX_LEN));

    // Code bit for the current walk position, MSB first
    assign bit_idx   = POS_W'(r_len - LEN_W'(1) - r_pos);
    assign add_b     = r_code[bit_idx];
    assign cur_count = r_count[r_tbl];
    assign need      = r_len - r_pos;
    assign fits      = ({1'b0, cur_count} + (CNT_W+1)'(need)) <= (CNT_W+1)'(NODES);

    // Node read: entries past the fill count read as empty
    assign rd_node = r_rd_ok ? mem_q : '0;

    always_comb begin
        rd_tbl = r_tbl;
        rd_idx = '0;
        case (r_state)
            S_IDLE: begin
                rd_tbl = i_table_req;
                rd_idx = (i_mode == MODE_DECODE) ? r_cursor[i_table_req] : '0;
            end
            S_DEC_CUR: rd_idx = rd_node.kid[r_bit];
            S_ADD_CHK: rd_idx = rd_node.kid[add_b];
            default:   rd_idx = '0;
        endcase
    end

    assign rd_ok = (r_count[rd_tbl] > CNT_W'(1)) && ({1'b0, rd_idx} < r_count[rd_tbl]);

    vtd_node_mem u_node_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr ({r_tbl, mem_widx}),
        .i_wdata (mem_wdata),
        .i_raddr ({rd_tbl, rd_idx}),
        .o_rdata (mem_q)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc_in) begin
                    if (tbl_ok && i_mode == MODE_DECODE) begin
                        n_state = S_DEC_CUR;
                    end else if (tbl_ok && i_mode == MODE_ADD && len_ok) begin
                        n_state = S_ADD_CHK;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_DEC_CUR: n_state = rd_node.has[r_bit] ? S_DEC_KID : S_RESP;
            S_DEC_KID: n_state = S_RESP;
            S_ADD_CHK: begin
                if ((r_pos != '0 && rd_node.leaf) || r_pos == r_len) begin
                    n_state = S_RESP;
                end else if (rd_node.has[add_b]) begin
                    n_state = S_ADD_CHK;
                end else if (!fits) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_ADD_NEW;
                end
            end
            S_ADD_NEW: n_state = (r_pos == r_len) ? S_RESP : S_ADD_NEW;
            S_RESP:    n_state = slot_free ? S_IDLE : S_RESP;
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath and memory writes
    always_comb begin
        n_pos        = r_pos;
        n_cur        = r_cur;
        n_count      = r_count;
        n_cursor     = r_cursor;
        n_res_status = r_res_status;
        n_res_symbol = r_res_symbol;
        mem_we       = 1'b0;
        mem_widx     = r_cur;
        mem_wdata    = rd_node;
        case (r_state)
            S_IDLE: begin
                n_pos        = '0;
                n_cur        = '0;
                n_res_status = ST_INVALID;
                n_res_symbol = '0;
                if (acc_in && tbl_ok && i_mode == MODE_CLEAR) begin
                    n_count[i_table_req]  = CNT_W'(1);
                    n_cursor[i_table_req] = '0;
                    n_res_status          = ST_CLEARED;
                end
            end
            S_DEC_CUR: begin
                n_cur = rd_node.kid[r_bit];
                if (!rd_node.has[r_bit]) begin
                    n_cursor[r_tbl] = '0;
                    n_res_status    = ST_INVALID;
                end
            end
            S_DEC_KID: begin
                if (rd_node.leaf) begin
                    n_cursor[r_tbl] = '0;
                    n_res_status    = ST_SYMBOL;
                    n_res_symbol    = rd_node.val;
                end else begin
                    n_cursor[r_tbl] = r_cur;
                    n_res_status    = ST_MORE;
                end
            end
            S_ADD_CHK: begin
                if ((r_pos != '0 && rd_node.leaf) || r_pos == r_len) begin
                    n_res_status = ST_CONFLICT;
                end else if (rd_node.has[add_b]) begin
                    // follow the existing branch
                    n_cur = rd_node.kid[add_b];
                    n_pos = r_pos + LEN_W'(1);
                end else if (!fits) begin
                    n_res_status = ST_FULL;
                end else begin
                    // link the first new node into the last existing one
                    mem_we                = 1'b1;
                    mem_widx              = r_cur;
                    mem_wdata.has[add_b]  = 1'b1;
                    mem_wdata.kid[add_b]  = cur_count[NODE_W-1:0];
                    n_pos                 = r_pos + LEN_W'(1);
                end
            end
            S_ADD_NEW: begin
                // create one node per cycle, the last one a leaf
                mem_we    = 1'b1;
                mem_widx  = cur_count[NODE_W-1:0];
                mem_wdata = '0;
                n_count[r_tbl] = cur_count + CNT_W'(1);
                if (r_pos == r_len) begin
                    mem_wdata.leaf = 1'b1;
                    mem_wdata.val  = r_val;
                    n_res_status   = ST_ADDED;
                end else begin
                    mem_wdata.has[add_b] = 1'b1;
                    mem_wdata.kid[add_b] = cur_count[NODE_W-1:0] + NODE_W'(1);
                    n_pos                = r_pos + LEN_W'(1);
                end
            end
            default: begin
                n_pos = r_pos;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_ok   <= 1'b0;
            r_o_valid <= 1'b0;
            for (int t = 0; t < TABLES; t++) begin
                r_count[t]  <= CNT_W'(1);
                r_cursor[t] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_rd_ok  <= rd_ok;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            if (r_state == S_RESP && slot_free) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_mode <= i_mode;
            r_tbl  <= i_table_req;
            r_bit  <= i_bit_req;
            r_val  <= i_value;
            r_len  <= i_code_len;
            r_code <= i_code;
        end
        r_pos        <= n_pos;
        r_cur        <= n_cur;
        r_res_status <= n_res_status;
        r_res_symbol <= n_res_symbol;
        if (r_state == S_RESP && slot_free) begin
            r_o_status <= r_res_status;
            r_o_symbol <= r_res_symbol;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_status = r_o_status;
    assign o_symbol = r_o_symbol;

`ifndef NO_ASSERTIONS
    a_write_only_in_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_mode == MODE_ADD) &&
                   (r_state == S_ADD_CHK || r_state == S_ADD_NEW))
        else $error("node write outside an add");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_in |=> r_state != S_IDLE)
        else $error("accepted item produced no work");

    a_symbol_only_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_SYMBOL) |-> o_symbol == '0)
        else $error("symbol driven without a decoded symbol");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count[0] <= CNT_W'(NODES) && r_count[0] != '0)
        else $error("node count out of range");

    a_cursor_in_tree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_cursor[0]} < r_count[0])
        else $error("walk cursor beyond allocated nodes");
`endif

endmodule

### hw/rtl/vtd_node_mem.sv
module vtd_node_mem
    import vtd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_node             i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output t_node             o_rdata
);

    t_node r_mem [TABLES*NODES];
    t_node r_rdata;

    // Write one node
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read one node, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
